@@ rtl/adsr_pkg.sv @@
// ----------------------------------------------------------------------------
// adsr_pkg
// shared types and constants of the envelope generator
// ----------------------------------------------------------------------------
package adsr_pkg;

   localparam int CurveDepth = 256;
   localparam int LevelBits  = 12;
   localparam int IdxBits    = $clog2(CurveDepth);
   localparam int DivNumBits = 32 + IdxBits;
   localparam int DivDenBits = 32;
   localparam int DivCntBits = $clog2(DivNumBits + 1);
   localparam int CsrIdxBits = 3;
   localparam int CsrBits    = 32;

   localparam logic [LevelBits-1:0] LevelMax = {LevelBits{1'b1}};

   typedef enum logic [2:0] {
      REQ_TICK     = 3'd0,
      REQ_NOTE_ON  = 3'd1,
      REQ_NOTE_OFF = 3'd2,
      REQ_ATK_WR   = 3'd3,
      REQ_FALL_WR  = 3'd4
   } req_code_type;

   typedef enum logic [CsrIdxBits-1:0] {
      CSR_RESOLUTION = 3'd0,
      CSR_ATTACK     = 3'd1,
      CSR_DECAY      = 3'd2,
      CSR_SUSTAIN    = 3'd3,
      CSR_RELEASE    = 3'd4,
      CSR_RETRIGGER  = 3'd5
   } csr_code_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EVAL,
      S_IDX,
      S_IDX_DIV,
      S_READ,
      S_MUL,
      S_MAP,
      S_MAP_DIV,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_ATTACK,
      PH_DECAY,
      PH_RELEASE
   } phase_type;

   typedef struct packed {
      logic                  start;
      logic [DivNumBits-1:0] dividend;
      logic [DivDenBits-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DivNumBits-1:0] quotient;
   } div_rsp_type;

endpackage

@@ rtl/adsr_if.sv @@
// ----------------------------------------------------------------------------
// adsr request and response channels
// valid/ready channels carrying the request and response payloads
// ----------------------------------------------------------------------------
interface adsr_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [7:0]  table_index;
   logic [11:0] table_value;

   modport source (output valid, req_type, table_index, table_value, input ready);
   modport sink (input valid, req_type, table_index, table_value, output ready);
endinterface

interface adsr_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] level;
   logic        note_held;

   modport source (output valid, level, note_held, input ready);
   modport sink (input valid, level, note_held, output ready);
endinterface

@@ rtl/adsr_div.sv @@
// ----------------------------------------------------------------------------
// adsr_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module adsr_div (
   input  logic                 clock,
   input  logic                 reset,
   input  adsr_pkg::div_req_type div_req,
   output adsr_pkg::div_rsp_type div_rsp
);
   import adsr_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [DivCntBits-1:0] cnt_ff;
   logic [DivDenBits:0]   rem_ff;
   logic [DivNumBits-1:0] quo_ff;
   logic [DivDenBits-1:0] den_ff;
   logic [DivDenBits:0]   trial;
   logic                  fits;

   assign trial = {rem_ff[DivDenBits-1:0], quo_ff[DivNumBits-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DivCntBits'(DivNumBits);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DivCntBits'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quo_ff <= div_req.dividend;
         den_ff <= div_req.divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? trial - {1'b0, den_ff} : trial;
         quo_ff <= {quo_ff[DivNumBits-2:0], fits};
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> busy_ff) else $error("divider did not start");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !div_req.start) else $error("divider restarted while busy");

endmodule

@@ rtl/adsr_envelope_generator.sv @@
// ----------------------------------------------------------------------------
// adsr_envelope_generator
// adsr envelope with curve tables in ram, shared serial divider
// ----------------------------------------------------------------------------
// tick transaction: evaluation, index division, table read, multiply and map
//   division, then response; evaluation alone when the level only holds
// note and table transactions: no evaluation, straight to response
// one transaction in flight; next accepted while response waits
// reset clears time, note and level state; curve tables undefined until written
// ----------------------------------------------------------------------------
module adsr_envelope_generator (
   input  logic                              clock,
   input  logic                              reset,
   adsr_req_if.sink                          req,
   adsr_rsp_if.source                        rsp,
   input  logic                              csr_we,
   input  logic [adsr_pkg::CsrIdxBits-1:0]   csr_index,
   input  logic [adsr_pkg::CsrBits-1:0]      csr_wdata
);
   import adsr_pkg::*;

   logic [12:0]          resolution_ff;
   logic [31:0]          attack_time_ff;
   logic [31:0]          decay_time_ff;
   logic [11:0]          sustain_ff;
   logic [31:0]          release_time_ff;
   logic                 retrigger_ff;

   logic [31:0]          time_now_ff;
   logic [31:0]          note_on_ff;
   logic [31:0]          note_off_ff;
   logic [7:0]           held_ff;
   logic [LevelBits-1:0] atk_start_ff;
   logic [LevelBits-1:0] rel_start_ff;
   logic [LevelBits-1:0] out_level_ff;

   logic [LevelBits-1:0] atk_mem [CurveDepth];
   logic [LevelBits-1:0] fall_mem [CurveDepth];
   logic [LevelBits-1:0] atk_rd_ff;
   logic [LevelBits-1:0] fall_rd_ff;

   state_type            state_ff, state_in;
   phase_type            phase_ff;
   logic [31:0]          elapsed_ff;
   logic [31:0]          span_ff;
   logic [IdxBits-1:0]   idx_ff;
   logic [23:0]          mag_ff;
   logic                 neg_ff;
   logic [LevelBits-1:0] lo_ff;

   logic                 rsp_valid_ff;
   logic [LevelBits-1:0] rsp_level_ff;
   logic                 rsp_held_ff;

   logic                 accept;
   logic                 slot_free;
   logic [LevelBits-1:0] top;
   logic [LevelBits-1:0] sus;
   logic [31:0]          e_on;
   logic [31:0]          e_off;
   logic [32:0]          ad_sum;
   logic [LevelBits-1:0] curve_x;
   logic [LevelBits-1:0] hi_sel;
   logic signed [13:0]   diff;
   logic signed [27:0]   prod;
   logic [27:0]          prod_mag;
   logic signed [27:0]   mapped;
   logic [7:0]           held_dec;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   adsr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      if (resolution_ff < 13'd2) begin
         top = LevelBits'(1);
      end else if (resolution_ff > 13'd4096) begin
         top = LevelMax;
      end else begin
         top = LevelBits'(resolution_ff - 13'd1);
      end
      sus = (sustain_ff > top) ? top : sustain_ff;
   end

   assign e_on     = time_now_ff - note_on_ff;
   assign e_off    = time_now_ff - note_off_ff;
   assign ad_sum   = {1'b0, attack_time_ff} + {1'b0, decay_time_ff};
   assign held_dec = (held_ff != 8'd0) ? held_ff - 8'd1 : 8'd0;

   assign curve_x  = (phase_ff == PH_ATTACK) ? atk_rd_ff : fall_rd_ff;
   assign hi_sel   = (phase_ff == PH_RELEASE) ? rel_start_ff : top;
   assign diff     = $signed({2'b00, hi_sel}) - $signed({2'b00, lo_ff});
   assign prod     = $signed({2'b00, curve_x}) * diff;
   assign prod_mag = prod[27] ? 28'(-prod) : 28'(prod);

   assign mapped = (neg_ff ? -$signed({4'b0, div_rsp.quotient[23:0]})
                           : $signed({4'b0, div_rsp.quotient[23:0]}))
                   + $signed({16'b0, lo_ff});

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = {elapsed_ff, {IdxBits{1'b0}}};
      div_req.divisor  = span_ff;
      unique case (state_ff)
         S_IDX: begin
            div_req.start = 1'b1;
         end
         S_MAP: begin
            div_req.start    = 1'b1;
            div_req.dividend = DivNumBits'(mag_ff);
            div_req.divisor  = DivDenBits'(top);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req.req_type == REQ_TICK) ? S_EVAL : S_DONE;
            end
         end
         S_EVAL: begin
            if (note_off_ff < note_on_ff) begin
               state_in = (ad_sum > {1'b0, e_on}) ? S_IDX : S_DONE;
            end else if (note_off_ff > note_on_ff) begin
               state_in = (e_off < release_time_ff) ? S_IDX : S_DONE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_IDX:     state_in = S_IDX_DIV;
         S_IDX_DIV: if (div_rsp.done) state_in = S_READ;
         S_READ:    state_in = S_MUL;
         S_MUL:     state_in = S_MAP;
         S_MAP:     state_in = S_MAP_DIV;
         S_MAP_DIV: if (div_rsp.done) state_in = S_DONE;
         S_DONE:    if (slot_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         resolution_ff   <= 13'd4096;
         attack_time_ff  <= 32'd1000;
         decay_time_ff   <= 32'd1000;
         sustain_ff      <= 12'd2048;
         release_time_ff <= 32'd1000;
         retrigger_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RESOLUTION: resolution_ff   <= csr_wdata[12:0];
            CSR_ATTACK:     attack_time_ff  <= csr_wdata;
            CSR_DECAY:      decay_time_ff   <= csr_wdata;
            CSR_SUSTAIN:    sustain_ff      <= csr_wdata[11:0];
            CSR_RELEASE:    release_time_ff <= csr_wdata;
            CSR_RETRIGGER:  retrigger_ff    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // curve tables
   always_ff @(posedge clock) begin
      if (accept && req.req_type == REQ_ATK_WR) begin
         atk_mem[req.table_index] <= req.table_value;
      end
      if (accept && req.req_type == REQ_FALL_WR) begin
         fall_mem[req.table_index] <= req.table_value;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         atk_rd_ff  <= atk_mem[idx_ff];
         fall_rd_ff <= fall_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_now_ff  <= '0;
         note_on_ff   <= '0;
         note_off_ff  <= '0;
         held_ff      <= '0;
         atk_start_ff <= '0;
         rel_start_ff <= '0;
         out_level_ff <= '0;
      end else begin
         if (accept) begin
            case (req.req_type)
               REQ_TICK: time_now_ff <= time_now_ff + 32'd1;
               REQ_NOTE_ON: begin
                  note_on_ff   <= time_now_ff;
                  atk_start_ff <= retrigger_ff ? '0 : out_level_ff;
                  if (held_ff != 8'd255) held_ff <= held_ff + 8'd1;
               end
               REQ_NOTE_OFF: begin
                  held_ff <= held_dec;
                  if (held_dec == 8'd0) begin
                     note_off_ff  <= time_now_ff;
                     rel_start_ff <= out_level_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         if (state_ff == S_EVAL) begin
            if (note_off_ff < note_on_ff) begin
               if (ad_sum <= {1'b0, e_on}) out_level_ff <= sus;
            end else if (note_off_ff > note_on_ff) begin
               if (e_off >= release_time_ff) out_level_ff <= '0;
            end
         end
         if (state_ff == S_MAP_DIV && div_rsp.done) begin
            if (mapped < 0) begin
               out_level_ff <= '0;
            end else if (mapped > $signed({16'b0, LevelMax})) begin
               out_level_ff <= LevelMax;
            end else begin
               out_level_ff <= mapped[LevelBits-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_EVAL) begin
         if (note_off_ff < note_on_ff) begin
            if (e_on < attack_time_ff) begin
               phase_ff   <= PH_ATTACK;
               elapsed_ff <= e_on;
               span_ff    <= attack_time_ff;
               lo_ff      <= atk_start_ff;
            end else begin
               phase_ff   <= PH_DECAY;
               elapsed_ff <= e_on - attack_time_ff;
               span_ff    <= decay_time_ff;
               lo_ff      <= sus;
            end
         end else begin
            phase_ff   <= PH_RELEASE;
            elapsed_ff <= e_off;
            span_ff    <= release_time_ff;
            lo_ff      <= '0;
         end
      end
      if (state_ff == S_IDX_DIV && div_rsp.done) begin
         idx_ff <= div_rsp.quotient[IdxBits-1:0];
      end
      if (state_ff == S_MUL) begin
         mag_ff <= prod_mag[23:0];
         neg_ff <= prod[27];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_DONE && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && slot_free) begin
         rsp_level_ff <= out_level_ff;
         rsp_held_ff  <= (held_ff != 8'd0);
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.level     = rsp_level_ff;
   assign rsp.note_held = rsp_held_ff;

   a_tick_eval: assert property (@(posedge clock) disable iff (reset)
      (accept && req.req_type == REQ_TICK) |=> state_ff == S_EVAL)
      else $error("tick did not start evaluation");
   a_other_done: assert property (@(posedge clock) disable iff (reset)
      (accept && req.req_type != REQ_TICK) |=> state_ff == S_DONE)
      else $error("non-tick transaction not answered");
   a_map_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAP_DIV && div_rsp.done) |=> state_ff == S_DONE)
      else $error("map result lost");
   a_held_sat: assert property (@(posedge clock) disable iff (reset)
      (held_ff == 8'd255 && accept && req.req_type == REQ_NOTE_ON) |=> held_ff == 8'd255)
      else $error("held count wrapped");

endmodule
